### src/tif_pkg.sv
package tif_pkg;

	// stream layout
	localparam int IN_DATA_W  = 8;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 5;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_REPEAT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_STOP_BITS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_SAMPLES = 2'd2;

	localparam logic [9:0]  SYNC_REPEAT_RST     = 10'd256;
	localparam logic [9:0]  GAP_STOP_BITS_RST   = 10'd100;
	localparam logic [15:0] SILENCE_SAMPLES_RST = 16'd15000;

	// input commands
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_GAP     = 2'd1;
	localparam logic [1:0] KIND_SILENCE = 2'd2;

	// result sections
	localparam logic [2:0] SEC_SYNC   = 3'd0;
	localparam logic [2:0] SEC_MARKER = 3'd1;
	localparam logic [2:0] SEC_HEADER = 3'd2;
	localparam logic [2:0] SEC_NAME   = 3'd3;
	localparam logic [2:0] SEC_DATA   = 3'd4;

	// tape bytes
	localparam logic [7:0] SYNC_BYTE = 8'h16;
	localparam logic [7:0] MARK_BYTE = 8'h24;
	localparam logic [7:0] NAME_END  = 8'h00;

	// header layout
	localparam int HEADER_BYTES = 9;
	localparam logic [3:0] HDR_END_HI   = 4'd4;
	localparam logic [3:0] HDR_END_LO   = 4'd5;
	localparam logic [3:0] HDR_START_HI = 4'd6;
	localparam logic [3:0] HDR_START_LO = 4'd7;

	// output queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEEK,
		PH_HEADER,
		PH_NAME,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  section;
		logic [7:0]  byte_value;
		logic [12:0] frame_word;
		logic [15:0] repeat_count;
		logic        last;
	} res_t;

	// start bit, data lsb first, odd parity, three stop bits
	function automatic logic [12:0] frame_of(input logic [7:0] b);
		frame_of = {3'b111, ~(^b), b, 1'b0};
	endfunction

	function automatic res_t make_frame(input logic [2:0] section, input logic [7:0] b,
			input logic [15:0] count);
		res_t r;
		r.kind         = KIND_FRAME;
		r.section      = section;
		r.byte_value   = b;
		r.frame_word   = frame_of(b);
		r.repeat_count = count;
		r.last         = 1'b0;
		make_frame = r;
	endfunction

	function automatic res_t make_plain(input logic [1:0] kind, input logic [2:0] section,
			input logic [15:0] count);
		res_t r;
		r.kind         = kind;
		r.section      = section;
		r.byte_value   = '0;
		r.frame_word   = '0;
		r.repeat_count = count;
		r.last         = 1'b0;
		make_plain = r;
	endfunction

endpackage

### src/tape_image_framer_unit.sv
// Tape image framer: takes one tape image byte (or an end-of-tape command) per transaction
// and turns it into serial frame results: a sync run and marker frame, header frames, name
// frames, a stop-bit gap and data frames, plus a silence result at end of tape. An input
// transaction is accepted every cycle as long as results drain at the same pace; the
// marker byte and the name terminator each give two results. The four-entry output
// queue sets the rate: the input register advances only while the queue has room for
// two results. With an empty queue the first result passes through the input register
// and then the output queue before it is presented on the output stream. Configuration
// writes are taken at any time but must only be issued while the block is idle.
module tape_image_framer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [tif_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // tape_byte[7:0]
	input  logic [tif_pkg::IN_USER_W-1:0]        s_axis_tuser,  // command[0]
	// result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [tif_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // byte_value, frame_word, repeat_count
	output logic [tif_pkg::OUT_USER_W-1:0]       m_axis_tuser,  // kind[1:0], section[4:2]
	output logic                                 m_axis_tlast,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tif_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tif_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import tif_pkg::*;

	// configuration registers
	logic [9:0]  sync_repeat_q;
	logic [9:0]  gap_stop_bits_q;
	logic [15:0] silence_samples_q;

	// input register
	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;

	// parser state
	phase_t      phase_q, phase_d;
	logic [3:0]  header_index_q, header_index_d;
	logic [15:0] end_address_q, end_address_d;
	logic [15:0] start_address_q, start_address_d;
	logic [16:0] data_remaining_q, data_remaining_d;

	// results of the current item
	res_t        res0, res1;
	logic [1:0]  res_n;

	// output queue
	res_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic        advance;
	logic [1:0]  push_n;
	logic        pop;
	logic [3:0]  header_inc;
	logic [16:0] data_dec;
	res_t        head;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_repeat_q     <= SYNC_REPEAT_RST;
			gap_stop_bits_q   <= GAP_STOP_BITS_RST;
			silence_samples_q <= SILENCE_SAMPLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SYNC_REPEAT:     sync_repeat_q     <= cfg_data[9:0];
				CFG_GAP_STOP_BITS:   gap_stop_bits_q   <= cfg_data[9:0];
				CFG_SILENCE_SAMPLES: silence_samples_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register moves on when the queue has room for two results
	assign advance       = valid_s1 && (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= s_axis_tuser[0];
			byte_s1 <= s_axis_tdata;
		end
	end

	// results for the item in the input register
	always_comb begin
		res0  = '0;
		res1  = '0;
		res_n = 2'd0;
		if (cmd_s1 == CMD_END) begin
			res0  = make_plain(KIND_SILENCE, SEC_SYNC, silence_samples_q);
			res_n = 2'd1;
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_SEEK: begin
					if (byte_s1 == MARK_BYTE) begin
						res0  = make_frame(SEC_SYNC, SYNC_BYTE, {6'd0, sync_repeat_q});
						res1  = make_frame(SEC_MARKER, MARK_BYTE, 16'd1);
						res_n = 2'd2;
					end
				end
				PH_HEADER: begin
					res0  = make_frame(SEC_HEADER, byte_s1, 16'd1);
					res_n = 2'd1;
				end
				PH_NAME: begin
					res0  = make_frame(SEC_NAME, byte_s1, 16'd1);
					res_n = 2'd1;
					if (byte_s1 == NAME_END) begin
						res1  = make_plain(KIND_GAP, SEC_NAME, {6'd0, gap_stop_bits_q});
						res_n = 2'd2;
					end
				end
				PH_DATA: begin
					res0  = make_frame(SEC_DATA, byte_s1, 16'd1);
					res_n = 2'd1;
				end
				default: ;
			endcase
		end
		if (res_n == 2'd1) res0.last = 1'b1;
		if (res_n == 2'd2) res1.last = 1'b1;
	end

	assign header_inc = header_index_q + 4'd1;
	assign data_dec   = (data_remaining_q != 17'd0) ? data_remaining_q - 17'd1 : 17'd0;

	// next parser state
	always_comb begin
		phase_d          = phase_q;
		header_index_d   = header_index_q;
		end_address_d    = end_address_q;
		start_address_d  = start_address_q;
		data_remaining_d = data_remaining_q;
		if (cmd_s1 == CMD_END) begin
			phase_d          = PH_IDLE;
			header_index_d   = '0;
			end_address_d    = '0;
			start_address_d  = '0;
			data_remaining_d = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_d = (byte_s1 == SYNC_BYTE) ? PH_SEEK : PH_IDLE;
				end
				PH_SEEK: begin
					if (byte_s1 == MARK_BYTE) begin
						header_index_d = '0;
						phase_d        = PH_HEADER;
					end
				end
				PH_HEADER: begin
					// address capture, high byte first
					priority if (header_index_q == HDR_END_HI)
						end_address_d = {byte_s1, end_address_q[7:0]};
					else if (header_index_q == HDR_END_LO)
						end_address_d = {end_address_q[15:8], byte_s1};
					else if (header_index_q == HDR_START_HI)
						start_address_d = {byte_s1, start_address_q[7:0]};
					else if (header_index_q == HDR_START_LO)
						start_address_d = {start_address_q[15:8], byte_s1};
					if (header_inc >= 4'(HEADER_BYTES)) begin
						header_index_d = '0;
						phase_d        = PH_NAME;
					end else begin
						header_index_d = header_inc;
					end
				end
				PH_NAME: begin
					if (byte_s1 == NAME_END) begin
						if (end_address_q >= start_address_q) begin
							data_remaining_d = {1'b0, end_address_q} - {1'b0, start_address_q}
								+ 17'd1;
							phase_d = PH_DATA;
						end else begin
							data_remaining_d = '0;
							phase_d          = PH_IDLE;
						end
					end
				end
				PH_DATA: begin
					data_remaining_d = data_dec;
					if (data_dec == 17'd0) phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			header_index_q   <= '0;
			end_address_q    <= '0;
			start_address_q  <= '0;
			data_remaining_q <= '0;
		end else if (advance) begin
			phase_q          <= phase_d;
			header_index_q   <= header_index_d;
			end_address_q    <= end_address_d;
			start_address_q  <= start_address_d;
			data_remaining_q <= data_remaining_d;
		end
	end

	// output queue
	assign push_n = advance ? res_n : 2'd0;
	assign pop    = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) queue_q[wr_ptr_q] <= res0;
		if (push_n == 2'd2) queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			cnt_q    <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	// result stream
	assign head          = queue_q[rd_ptr_q];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {3'b000, head.repeat_count, head.frame_word, head.byte_value};
	assign m_axis_tuser  = {head.section, head.kind};
	assign m_axis_tlast  = head.last;

endmodule

### src/tif_checker.sv
module tif_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [tif_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	input  logic [tif_pkg::OUT_USER_W-1:0]       m_axis_tuser,
	input  logic                                 m_axis_tlast
);
	import tif_pkg::*;

	// a stalled result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// frame word matches its byte with start and stop bits in place
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == KIND_FRAME |->
			m_axis_tdata[8] == 1'b0 && m_axis_tdata[20:18] == 3'b111
			&& m_axis_tdata[16:9] == m_axis_tdata[7:0]
			&& m_axis_tdata[17] == ~(^m_axis_tdata[7:0]))
		else $error("malformed byte frame");

	// silence always closes its transaction group
	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == KIND_SILENCE |->
			m_axis_tlast && m_axis_tuser[4:2] == SEC_SYNC && m_axis_tdata[20:0] == '0)
		else $error("bad silence result");

	// gap follows the name terminator and ends the group
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == KIND_GAP |->
			m_axis_tlast && m_axis_tuser[4:2] == SEC_NAME && m_axis_tdata[20:0] == '0)
		else $error("bad gap result");

	// sync run is always followed by the marker frame
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == KIND_FRAME && m_axis_tuser[4:2] == SEC_SYNC
			|-> !m_axis_tlast)
		else $error("sync run without marker");

endmodule

bind tape_image_framer_unit tif_checker u_tif_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
